// ===== design/radio_frame_receiver_crc8_unit_assert.svh =====
// Assertion macros for the radio frame receiver, empty for synthesis.
`ifndef RADIO_FRAME_RECEIVER_CRC8_UNIT_ASSERT_SVH
`define RADIO_FRAME_RECEIVER_CRC8_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define RFCRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RFCRC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define RFCRC_ASSERT(label, prop, msg)
`define RFCRC_ASSERT_RST(label, prop, msg)
`endif

`endif

// ===== design/rfcrc_pkg.sv =====
// Types, codes and constants shared by the radio frame receiver modules.
package rfcrc_pkg;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [7:0]  BroadcastAddr = 8'hFF;
  localparam logic [7:0]  CrcPoly       = 8'hD5;
  localparam logic [15:0] TimeoutReset  = 16'hFFFF;
  localparam logic [15:0] TicksMax      = 16'hFFFF;

  localparam logic [CfgIdxW-1:0] CfgPrimaryAddr = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgReceiveAddr = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTimeout     = 2'd2;

  localparam logic CmdByte = 1'b0;
  localparam logic CmdTick = 1'b1;

  typedef enum logic [1:0] {
    KindPayload = 2'd0,
    KindEnd     = 2'd1,
    KindReject  = 2'd2
  } item_kind_e;

  typedef enum logic [4:0] {
    PhIdle   = 5'b00001,
    PhSender = 5'b00010,
    PhFlag   = 5'b00100,
    PhLength = 5'b01000,
    PhData   = 5'b10000
  } phase_e;

  typedef struct packed {
    item_kind_e item_kind;
    logic [7:0] data_byte;
    logic       last_payload;
    logic [7:0] target_address;
    logic [7:0] sender_address;
    logic [7:0] frame_flag;
    logic [7:0] payload_count;
    logic       frame_error;
    logic       timed_out;
  } result_t;

endpackage

// ===== design/rfcrc_crc8.sv =====
// One-byte CRC-8 update, polynomial 0xD5, MSB first.
module rfcrc_crc8 (
  input  logic [7:0] crc_i,
  input  logic [7:0] byte_i,
  output logic [7:0] crc_o
);

  always_comb begin
    logic [7:0] v;
    v = crc_i ^ byte_i;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ rfcrc_pkg::CrcPoly;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    crc_o = v;
  end

endmodule

// ===== design/rfcrc_out_stage.sv =====
// Result register between the frame logic and the output stream.
module rfcrc_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  rfcrc_pkg::result_t res_i,
  input  logic               ready_i,
  output logic               can_load_o,
  output logic               valid_o,
  output rfcrc_pkg::result_t res_o
);

  logic               valid_q, valid_d;
  rfcrc_pkg::result_t res_q;

  assign can_load_o = ~valid_q | ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== design/radio_frame_receiver_crc8_unit.sv =====
// Top level of the radio frame receiver with CRC-8 check.
//
//  channel   | direction | carries
//  s_axis    | in        | tuser: cmd; tdata: rx_byte
//  m_axis    | out       | tuser: item_kind; tlast: last_payload; tdata: result fields
//  cfg       | in        | register write: index, data
//
// One request is taken every cycle unless the output register is stalled; its result,
// if any, appears in that register in the cycle after acceptance.
// The CRC update is eight unrolled steps. Reset clears the phase, the held header and
// the tick counter. A stalled result holds the output register; a new request is
// taken in the cycle that register is emptied.
`include "radio_frame_receiver_crc8_unit_assert.svh"

module radio_frame_receiver_crc8_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] rx_byte
  input  logic                           s_axis_tuser,  // [0] cmd
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] data_byte, [15:8] target_address, [23:16] sender_address,
  // [31:24] frame_flag, [39:32] payload_count, [40] frame_error, [41] timed_out
  output logic [47:0]                    m_axis_tdata,
  output logic [1:0]                     m_axis_tuser,  // [1:0] item_kind
  output logic                           m_axis_tlast,
  input  logic                           cfg_we_i,
  input  logic [rfcrc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rfcrc_pkg::CfgDataW-1:0] cfg_data_i
);

  logic [7:0]  primary_addr_q, receive_addr_q;
  logic [15:0] timeout_q;

  rfcrc_pkg::phase_e phase_q, phase_d;
  logic [7:0]  target_q, target_d;
  logic [7:0]  sender_q, sender_d;
  logic [7:0]  flag_q, flag_d;
  logic [7:0]  frame_len_q, frame_len_d;
  logic [7:0]  byte_idx_q, byte_idx_d;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] ticks_q, ticks_d;

  logic               s_acc;
  logic               res_valid;
  rfcrc_pkg::result_t res;
  rfcrc_pkg::result_t res_out;
  logic [7:0]         crc_next;
  logic [15:0]        ticks_inc;
  logic [8:0]         idx_p1, idx_p2;

  assign s_acc = s_axis_tvalid & s_axis_tready;

  rfcrc_crc8 u_crc8 (
    .crc_i  (crc_q),
    .byte_i (s_axis_tdata),
    .crc_o  (crc_next)
  );

  assign ticks_inc = (ticks_q == rfcrc_pkg::TicksMax) ? ticks_q : ticks_q + 16'd1;
  assign idx_p1    = {1'b0, byte_idx_q} + 9'd1;
  assign idx_p2    = {1'b0, byte_idx_q} + 9'd2;

  always_comb begin
    phase_d     = phase_q;
    target_d    = target_q;
    sender_d    = sender_q;
    flag_d      = flag_q;
    frame_len_d = frame_len_q;
    byte_idx_d  = byte_idx_q;
    crc_d       = crc_q;
    ticks_d     = ticks_q;
    res_valid   = 1'b0;
    res         = '0;
    res.item_kind = rfcrc_pkg::KindEnd;
    res.target_address = target_q;
    res.sender_address = sender_q;
    res.frame_flag     = flag_q;
    if (s_acc) begin
      if (s_axis_tuser == rfcrc_pkg::CmdTick) begin
        if (phase_q != rfcrc_pkg::PhIdle) begin
          ticks_d = ticks_inc;
          if (ticks_inc >= timeout_q) begin
            res_valid       = 1'b1;
            res.frame_error = 1'b1;
            res.timed_out   = 1'b1;
            res.payload_count = (phase_q == rfcrc_pkg::PhData) ? byte_idx_q : 8'd0;
            phase_d = rfcrc_pkg::PhIdle;
          end
        end
      end else begin
        ticks_d = '0;
        unique case (phase_q)
          rfcrc_pkg::PhSender: begin
            sender_d = s_axis_tdata;
            phase_d  = rfcrc_pkg::PhFlag;
          end
          rfcrc_pkg::PhFlag: begin
            flag_d  = s_axis_tdata;
            phase_d = rfcrc_pkg::PhLength;
          end
          rfcrc_pkg::PhLength: begin
            frame_len_d = s_axis_tdata;
            byte_idx_d  = '0;
            crc_d       = '0;
            if (s_axis_tdata == 8'd0) begin
              res_valid       = 1'b1;
              res.frame_error = 1'b1;
              phase_d         = rfcrc_pkg::PhIdle;
            end else begin
              phase_d = rfcrc_pkg::PhData;
            end
          end
          rfcrc_pkg::PhData: begin
            crc_d     = crc_next;
            res_valid = 1'b1;
            if (idx_p1 >= {1'b0, frame_len_q}) begin
              res.payload_count = frame_len_q - 8'd1;
              res.frame_error   = (crc_next != 8'd0);
              phase_d           = rfcrc_pkg::PhIdle;
            end else begin
              res.item_kind    = rfcrc_pkg::KindPayload;
              res.data_byte    = s_axis_tdata;
              res.last_payload = (idx_p2 == {1'b0, frame_len_q});
              byte_idx_d       = idx_p1[7:0];
            end
          end
          default: begin
            if (s_axis_tdata == primary_addr_q || s_axis_tdata == receive_addr_q ||
                s_axis_tdata == rfcrc_pkg::BroadcastAddr) begin
              target_d    = s_axis_tdata;
              sender_d    = '0;
              flag_d      = '0;
              frame_len_d = '0;
              byte_idx_d  = '0;
              crc_d       = '0;
              phase_d     = rfcrc_pkg::PhSender;
            end else begin
              res_valid          = 1'b1;
              res                = '0;
              res.item_kind      = rfcrc_pkg::KindReject;
              res.target_address = s_axis_tdata;
              phase_d            = rfcrc_pkg::PhIdle;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primary_addr_q <= '0;
      receive_addr_q <= '0;
      timeout_q      <= rfcrc_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rfcrc_pkg::CfgPrimaryAddr: primary_addr_q <= cfg_data_i[7:0];
        rfcrc_pkg::CfgReceiveAddr: receive_addr_q <= cfg_data_i[7:0];
        rfcrc_pkg::CfgTimeout:     timeout_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= rfcrc_pkg::PhIdle;
      target_q    <= '0;
      sender_q    <= '0;
      flag_q      <= '0;
      frame_len_q <= '0;
      byte_idx_q  <= '0;
      crc_q       <= '0;
      ticks_q     <= '0;
    end else begin
      phase_q     <= phase_d;
      target_q    <= target_d;
      sender_q    <= sender_d;
      flag_q      <= flag_d;
      frame_len_q <= frame_len_d;
      byte_idx_q  <= byte_idx_d;
      crc_q       <= crc_d;
      ticks_q     <= ticks_d;
    end
  end

  rfcrc_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (s_acc & res_valid),
    .res_i      (res),
    .ready_i    (m_axis_tready),
    .can_load_o (s_axis_tready),
    .valid_o    (m_axis_tvalid),
    .res_o      (res_out)
  );

  assign m_axis_tuser = res_out.item_kind;
  assign m_axis_tlast = res_out.last_payload;
  assign m_axis_tdata = {6'd0, res_out.timed_out, res_out.frame_error, res_out.payload_count,
                         res_out.frame_flag, res_out.sender_address, res_out.target_address,
                         res_out.data_byte};

  `RFCRC_ASSERT(a_idle_tick_silent, (s_acc && s_axis_tuser == rfcrc_pkg::CmdTick && phase_q == rfcrc_pkg::PhIdle) |=> !m_axis_tvalid, "tick while idle produced a result")
  `RFCRC_ASSERT(a_end_to_idle, (s_acc && res_valid && res.item_kind == rfcrc_pkg::KindEnd) |=> phase_q == rfcrc_pkg::PhIdle, "frame end did not return to idle")
  `RFCRC_ASSERT(a_idx_in_frame, phase_q == rfcrc_pkg::PhData |-> byte_idx_q < frame_len_q, "byte index ran past frame length")
  `RFCRC_ASSERT(a_result_shown, (s_acc && res_valid) |=> m_axis_tvalid, "result lost on the way to the output register")
  `RFCRC_ASSERT_RST(a_reset_empty, !rst_ni |-> !m_axis_tvalid, "output valid during reset")

endmodule
